### hdl/dtc_pkg.sv
// Shared constants, status codes and state type for the domino tiling counter.
`timescale 1ns / 1ps

package dtc_pkg;

    localparam int MAX_ROWS_DEF = 8;
    localparam int MAX_COLS     = 64;
    localparam int DIM_W        = 7;
    localparam int COUNT_W      = 64;
    localparam int STATUS_W     = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_FINISH
    } t_state;

endpackage

### hdl/dtc_if.sv
// Valid/ready channel interfaces for requests and results of the tiling counter.
`timescale 1ns / 1ps

interface dtc_req_if;
    logic                       valid;
    logic                       ready;
    logic [dtc_pkg::DIM_W-1:0]  grid_rows;
    logic [dtc_pkg::DIM_W-1:0]  grid_cols;

    modport source (output valid, output grid_rows, output grid_cols, input ready);
    modport sink   (input valid, input grid_rows, input grid_cols, output ready);
endinterface

interface dtc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [dtc_pkg::COUNT_W-1:0]  tiling_count;
    logic [dtc_pkg::STATUS_W-1:0] status;

    modport source (output valid, output tiling_count, output status, input ready);
    modport sink   (input valid, input tiling_count, input status, output ready);
endinterface

### hdl/domino_tiling_counter.sv
// Domino tiling counter: cell-by-cell profile DP over a ping-pong count memory.
// For an even grid with h = min dim and w = max dim, each of the h*w cell steps
// sweeps 2^h profiles, one per cycle through the memory's two read ports, then
// waits in ST_WAIT so that its last write lands before the next step reads.
// Odd, empty or oversized grids skip the DP and go straight to ST_FINISH. One request at a time.
// Reset (sync, active low) clears the sequencer and output valid; no memory clear.
`timescale 1ns / 1ps

module domino_tiling_counter #(
    parameter int MAX_ROWS = dtc_pkg::MAX_ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtc_req_if.sink     i_req,
    dtc_rsp_if.source   o_rsp
);

    localparam int MW    = MAX_ROWS;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW    = MAX_ROWS + 1;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = dtc_pkg::COUNT_W;
    localparam int EW    = CW + 1;
    localparam int DW    = dtc_pkg::DIM_W;

    dtc_pkg::t_state r_state, n_state;

    // request setup
    logic [DW-1:0] h_dim, w_dim;
    logic          odd_area, too_large, trivial, special, accept;

    // sequencer
    logic [RW-1:0] r_h_last, r_row;
    logic [DW-1:0] r_w_last, r_col;
    logic [MW-1:0] r_full, r_n;
    logic          r_bank, r_first, r_dp_end;
    logic          ready, issue, load_out, out_free;

    // read side
    logic [MW-1:0] bit_r, bit_r1, a0, a1;
    logic          use1, row_last, stage_last, stage_final;

    // memory and pipe
    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rd0, r_rd1;
    logic          r_p_valid, r_p_wbank, r_p_use1, r_p_z0, r_p_z1, r_p_first, r_p_final;
    logic [MW-1:0] r_p_n;

    // write side
    logic [EW-1:0] d0, d1;
    logic [CW-1:0] sum, w_val;
    logic          carry, w_ovf;

    // result
    logic                         r_ovf, r_special;
    logic [CW-1:0]                r_count;
    logic [dtc_pkg::STATUS_W-1:0] r_status;
    logic                         r_out_valid;
    logic [CW-1:0]                r_out_count;
    logic [dtc_pkg::STATUS_W-1:0] r_out_status;

    assign h_dim     = (i_req.grid_rows < i_req.grid_cols) ? i_req.grid_rows : i_req.grid_cols;
    assign w_dim     = (i_req.grid_rows < i_req.grid_cols) ? i_req.grid_cols : i_req.grid_rows;
    assign odd_area  = i_req.grid_rows[0] & i_req.grid_cols[0];
    assign too_large = (32'(h_dim) > 32'(MAX_ROWS)) || (32'(w_dim) > 32'(dtc_pkg::MAX_COLS));
    assign trivial   = (h_dim == '0);
    assign special   = odd_area || too_large || trivial;
    assign accept    = i_req.valid && ready;
    assign out_free  = !r_out_valid || o_rsp.ready;

    assign row_last    = (r_row == r_h_last);
    assign stage_last  = (r_n == r_full);
    assign stage_final = row_last && (r_col == r_w_last);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dtc_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = special ? dtc_pkg::ST_FINISH : dtc_pkg::ST_RUN;
                end
            end
            dtc_pkg::ST_RUN: begin
                if (stage_last) begin
                    n_state = dtc_pkg::ST_WAIT;
                end
            end
            dtc_pkg::ST_WAIT: begin
                n_state = r_dp_end ? dtc_pkg::ST_FINISH : dtc_pkg::ST_RUN;
            end
            dtc_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = dtc_pkg::ST_IDLE;
                end
            end
            default: n_state = dtc_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        ready    = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            dtc_pkg::ST_IDLE:   ready    = 1'b1;
            dtc_pkg::ST_RUN:    issue    = 1'b1;
            dtc_pkg::ST_WAIT:   ;
            dtc_pkg::ST_FINISH: load_out = out_free;
            default:            ;
        endcase
    end

    // predecessors of profile r_n at cell r_row
    always_comb begin
        bit_r  = MW'(1) << r_row;
        bit_r1 = bit_r << 1;
        if (|(r_n & bit_r)) begin
            a0   = r_n ^ bit_r;
            a1   = r_n;
            use1 = 1'b0;
        end else begin
            a0   = r_n | bit_r;
            a1   = r_n & ~bit_r1;
            use1 = !row_last && |(r_n & bit_r1);
        end
    end

    // saturating sum; bit CW marks a true count beyond the 64-bit range
    always_comb begin
        d0 = r_p_first ? EW'(r_p_z0) : r_rd0;
        d1 = r_p_use1 ? (r_p_first ? EW'(r_p_z1) : r_rd1) : '0;
        {carry, sum} = {1'b0, d0[CW-1:0]} + {1'b0, d1[CW-1:0]};
        w_ovf = carry | d0[CW] | d1[CW];
        w_val = carry ? '1 : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtc_pkg::ST_IDLE;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= issue;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd0 <= r_mem[{r_bank, a0}];
        r_rd1 <= r_mem[{r_bank, a1}];
        if (r_p_valid) begin
            r_mem[{r_p_wbank, r_p_n}] <= {w_ovf, w_val};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_n     <= r_n;
        r_p_wbank <= ~r_bank;
        r_p_use1  <= use1;
        r_p_z0    <= (a0 == '0);
        r_p_z1    <= (a1 == '0);
        r_p_first <= r_first;
        r_p_final <= stage_final;

        if (accept) begin
            r_h_last  <= RW'(h_dim - 1'b1);
            r_w_last  <= w_dim - 1'b1;
            r_full    <= MW'((32'd1 << h_dim) - 32'd1);
            r_row     <= '0;
            r_col     <= '0;
            r_n       <= '0;
            r_bank    <= 1'b0;
            r_first   <= 1'b1;
            r_dp_end  <= 1'b0;
            r_ovf     <= 1'b0;
            r_special <= special;
            if (odd_area) begin
                r_count  <= '0;
                r_status <= dtc_pkg::STATUS_OK;
            end else if (too_large) begin
                r_count  <= '0;
                r_status <= dtc_pkg::STATUS_TOO_LARGE;
            end else begin
                r_count  <= CW'(1);
                r_status <= dtc_pkg::STATUS_OK;
            end
        end

        if (issue) begin
            if (stage_last) begin
                r_n      <= '0;
                r_bank   <= ~r_bank;
                r_first  <= 1'b0;
                r_dp_end <= stage_final;
                if (row_last) begin
                    r_row <= '0;
                    r_col <= r_col + 1'b1;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_n <= r_n + 1'b1;
            end
        end

        if (r_p_valid) begin
            r_ovf <= r_ovf | w_ovf;
            if (r_p_final && (r_p_n == '0)) begin
                r_count <= w_val;
            end
        end

        if (load_out) begin
            r_out_count <= r_count;
            if (r_special) begin
                r_out_status <= r_status;
            end else begin
                r_out_status <= r_ovf ? dtc_pkg::STATUS_OVERFLOW : dtc_pkg::STATUS_OK;
            end
        end
    end

    assign i_req.ready        = ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.tiling_count = r_out_count;
    assign o_rsp.status       = r_out_status;

endmodule
